[design/wfdt_pkg.sv]
`timescale 1ns / 1ps
package wfdt_pkg;

  localparam int AP_ENTRIES      = 32;
  localparam int STA_ENTRIES     = 32;
  localparam int SSID_BYTES      = 32;
  localparam int MAX_FRAME_BYTES = 4096;

  localparam int AIW  = $clog2(AP_ENTRIES);
  localparam int SIW  = $clog2(STA_ENTRIES);
  localparam int SAW  = $clog2(SSID_BYTES);
  localparam int KW   = $clog2(SSID_BYTES + 1);
  localparam int PW   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW   = 6;
  localparam int ID_W = 6;

  localparam logic [7:0] FT_PREQ  = 8'h40;
  localparam logic [7:0] FT_PRSP  = 8'h50;
  localparam logic [7:0] FT_BCN   = 8'h80;
  localparam logic [7:0] FT_QDATA = 8'h88;
  localparam logic [7:0] FT_DATA  = 8'h08;
  localparam logic [7:0] TAG_DS   = 8'h03;

  localparam int WALK_PREQ    = 24;
  localparam int WALK_MGMT    = 36;
  localparam int SSID_LEN_POS = 37;
  localparam int SSID_POS     = 38;
  localparam int ADDR1_POS    = 4;
  localparam int ADDR2_POS    = 10;
  localparam int MIN_FRAME    = 16;

  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_PREQ = 3'd1;
  localparam logic [2:0] CLS_PRSP = 3'd2;
  localparam logic [2:0] CLS_BCN  = 3'd3;
  localparam logic [2:0] CLS_DATA = 3'd4;

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [7:0]    ftype;
    logic [47:0]   addr1;
    logic [47:0]   addr2;
    logic [7:0]    sslen;
    logic [7:0]    chan;
    logic          seen;
  } frame_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

[design/wifi_frame_device_tracker.sv]
`timescale 1ns / 1ps
// channel | direction | tdata                              | tuser | tlast
// in_     | slave     | data_byte                          | kind  | last
// out_    | master    | class, ids, channel, assoc, status | -     | -
// A frame byte or a tick is taken only while idle. After the last byte the frame is
// classified; each table is searched entry by entry until a hit or a miss; the SSID is
// compared or copied byte by byte and the entry closed; a station may be relinked;
// then the result is issued.
// Reset (rst_n low, synchronous) empties both tables; no clearing pass.
// in_tready is low while a frame end is processed; a stalled result holds.
module wifi_frame_device_tracker import wfdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [2:0] frame_class, [8:3] ap_id, [9] ap_new,
                                  // [15:10] sta_id, [16] sta_new,
                                  // [24:17] channel_found, [25] assoc_changed,
                                  // [26] status, [31:27] zero
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIN  = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_HIT  = 4'd4;
  localparam logic [3:0] S_MISS = 4'd5;
  localparam logic [3:0] S_QRD  = 4'd6;
  localparam logic [3:0] S_QCMP = 4'd7;
  localparam logic [3:0] S_CRD  = 4'd8;
  localparam logic [3:0] S_CWR  = 4'd9;
  localparam logic [3:0] S_LK0  = 4'd10;
  localparam logic [3:0] S_LK1  = 4'd11;
  localparam logic [3:0] S_LK2  = 4'd12;
  localparam logic [3:0] S_LK3  = 4'd13;
  localparam logic [3:0] S_LK4  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [31:0]   sec_r, sec_nxt;
  logic [CW-1:0] ap_cnt_r, ap_cnt_nxt, sta_cnt_r, sta_cnt_nxt;
  logic [2:0]    cls_r, cls_nxt;
  logic [KW-1:0] slen_r, slen_nxt, k_r, k_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          tbl_r, tbl_nxt;
  logic [47:0]   key_r, key_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [ID_W-1:0] aid_r, aid_nxt, sid_r, sid_nxt, old_r, old_nxt;
  logic          anew_r, anew_nxt, snew_r, snew_nxt, moved_r, moved_nxt;
  logic          full_r, full_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [31:0]   out_tdata_r, out_tdata_nxt;

  logic          accept, byte_acc, clr, op_done, has_ssid;
  frame_t        frm;
  logic [KW-1:0] s_tmp;
  logic [PW-1:0] pos_rem;
  logic [2:0]    cls_tmp;
  logic [ID_W-1:0] sid_m1, aid_m1, old_m1, lnk_m1;

  logic          fs_we;
  logic [SAW-1:0] fs_waddr;
  logic [7:0]    fs_mem [SSID_BYTES];
  logic [7:0]    fs_q;

  logic [7:0]    ss_mem [AP_ENTRIES * SSID_BYTES];
  logic [7:0]    ss_q;
  logic          ss_we;

  logic [47:0]   ap_mac_mem [AP_ENTRIES];
  logic [KW-1:0] ap_len_mem [AP_ENTRIES];
  logic [CW-1:0] ap_tot_mem [AP_ENTRIES];
  logic [7:0]    ap_chan_mem [AP_ENTRIES];
  logic [31:0]   ap_time_mem [AP_ENTRIES];
  logic [47:0]   ap_mac_q;
  logic [KW-1:0] ap_len_q, ap_wlen;
  logic [CW-1:0] ap_tot_q, ap_wtot;
  logic [AIW-1:0] ap_raddr, ap_waddr;
  logic          ap_we_mac, ap_we_len, ap_we_tot, ap_we_chan, ap_we_time;

  logic [47:0]   sta_mac_mem [STA_ENTRIES];
  logic [ID_W-1:0] sta_link_mem [STA_ENTRIES];
  logic [7:0]    sta_chan_mem [STA_ENTRIES];
  logic [31:0]   sta_time_mem [STA_ENTRIES];
  logic [47:0]   sta_mac_q;
  logic [ID_W-1:0] sta_link_q, sta_wlink;
  logic [SIW-1:0] sta_raddr, sta_waddr;
  logic          sta_we_mac, sta_we_link, sta_we_chan, sta_we_time;

  logic [CW-1:0] cnt_sel;
  logic [47:0]   mac_sel;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign byte_acc   = accept && !in_tuser;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  wfdt_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (byte_acc),
    .clr       (clr),
    .data_byte (in_tdata),
    .frm       (frm)
  );

  assign fs_we    = byte_acc && frm.pos >= PW'(SSID_POS) &&
                    frm.pos < PW'(SSID_POS + SSID_BYTES);
  assign pos_rem  = frm.pos - PW'(SSID_POS);
  assign fs_waddr = pos_rem[SAW-1:0];

  assign has_ssid = (cls_r == CLS_PRSP) || (cls_r == CLS_BCN);
  assign cnt_sel  = tbl_r ? ap_cnt_r : sta_cnt_r;
  assign mac_sel  = tbl_r ? ap_mac_q : sta_mac_q;
  assign sid_m1   = sid_r - ID_W'(1);
  assign aid_m1   = aid_r - ID_W'(1);
  assign old_m1   = old_r - ID_W'(1);
  assign lnk_m1   = sta_link_q - ID_W'(1);

  always_comb begin
    case (state_r)
      S_LK1:   ap_raddr = lnk_m1[AIW-1:0];
      S_LK3:   ap_raddr = aid_m1[AIW-1:0];
      default: ap_raddr = idx_r[AIW-1:0];
    endcase
    case (state_r)
      S_LK2:   ap_waddr = old_m1[AIW-1:0];
      S_LK4:   ap_waddr = aid_m1[AIW-1:0];
      default: ap_waddr = idx_r[AIW-1:0];
    endcase
    sta_raddr = (state_r == S_LK0) ? sid_m1[SIW-1:0] : idx_r[SIW-1:0];
    sta_waddr = (state_r == S_LK1) ? sid_m1[SIW-1:0] : idx_r[SIW-1:0];
  end

  always_comb begin
    s_tmp = (frm.sslen > 8'(SSID_BYTES)) ? KW'(SSID_BYTES) : frm.sslen[KW-1:0];
    if (frm.pos < PW'(SSID_POS))
      s_tmp = '0;
    else if (pos_rem < PW'(s_tmp))
      s_tmp = pos_rem[KW-1:0];
    case (frm.ftype)
      FT_PREQ:  cls_tmp = CLS_PREQ;
      FT_PRSP:  cls_tmp = CLS_PRSP;
      FT_BCN:   cls_tmp = CLS_BCN;
      FT_QDATA: cls_tmp = CLS_DATA;
      FT_DATA:  cls_tmp = CLS_DATA;
      default:  cls_tmp = CLS_NONE;
    endcase
    if (frm.pos < PW'(MIN_FRAME))
      cls_tmp = CLS_NONE;
  end

  always_comb begin
    state_nxt      = state_r;
    sec_nxt        = sec_r;
    ap_cnt_nxt     = ap_cnt_r;
    sta_cnt_nxt    = sta_cnt_r;
    cls_nxt        = cls_r;
    slen_nxt       = slen_r;
    k_nxt          = k_r;
    ch_nxt         = ch_r;
    tbl_nxt        = tbl_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    aid_nxt        = aid_r;
    sid_nxt        = sid_r;
    old_nxt        = old_r;
    anew_nxt       = anew_r;
    snew_nxt       = snew_r;
    moved_nxt      = moved_r;
    full_nxt       = full_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    clr            = 1'b0;
    op_done        = 1'b0;
    ss_we          = 1'b0;
    ap_we_mac      = 1'b0;
    ap_we_len      = 1'b0;
    ap_we_tot      = 1'b0;
    ap_we_chan     = 1'b0;
    ap_we_time     = 1'b0;
    ap_wlen        = '0;
    ap_wtot        = '0;
    sta_we_mac     = 1'b0;
    sta_we_link    = 1'b0;
    sta_we_chan    = 1'b0;
    sta_we_time    = 1'b0;
    sta_wlink      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept && in_tuser)
          sec_nxt = sec_r + 32'd1;
        if (byte_acc && in_tlast)
          state_nxt = S_FIN;
      end
      S_FIN: begin
        cls_nxt   = cls_tmp;
        slen_nxt  = (cls_tmp == CLS_PRSP || cls_tmp == CLS_BCN) ? s_tmp : '0;
        ch_nxt    = (frm.seen && cls_tmp != CLS_NONE && cls_tmp != CLS_DATA) ?
                    frm.chan : 8'd0;
        aid_nxt   = '0;
        sid_nxt   = '0;
        anew_nxt  = 1'b0;
        snew_nxt  = 1'b0;
        moved_nxt = 1'b0;
        full_nxt  = 1'b0;
        idx_nxt   = '0;
        state_nxt = S_SRD;
        case (cls_tmp)
          CLS_PREQ: begin
            tbl_nxt = 1'b0;
            key_nxt = frm.addr2;
          end
          CLS_PRSP: begin
            tbl_nxt = 1'b0;
            key_nxt = frm.addr1;
          end
          CLS_BCN, CLS_DATA: begin
            tbl_nxt = 1'b1;
            key_nxt = frm.addr2;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SRD: begin
        state_nxt = (idx_r == cnt_sel) ? S_MISS : S_SCMP;
      end
      S_SCMP: begin
        if (mac_sel == key_r) begin
          state_nxt = S_HIT;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SRD;
        end
      end
      S_HIT: begin
        if (tbl_r) begin
          ap_we_time = 1'b1;
          ap_we_chan = (ch_r != 8'd0);
          aid_nxt    = ID_W'(idx_r) + ID_W'(1);
          k_nxt      = '0;
          if (!has_ssid)
            op_done = 1'b1;
          else if (ap_len_q != slen_r)
            state_nxt = S_CRD;
          else
            state_nxt = S_QRD;
        end else begin
          sta_we_time = 1'b1;
          sta_we_chan = (ch_r != 8'd0);
          sid_nxt     = ID_W'(idx_r) + ID_W'(1);
          op_done     = 1'b1;
        end
      end
      S_MISS: begin
        if (tbl_r) begin
          if (ap_cnt_r == CW'(AP_ENTRIES)) begin
            full_nxt = 1'b1;
            op_done  = 1'b1;
          end else begin
            ap_we_mac  = 1'b1;
            ap_we_time = 1'b1;
            ap_we_chan = 1'b1;
            ap_we_tot  = 1'b1;
            ap_we_len  = 1'b1;
            ap_cnt_nxt = ap_cnt_r + CW'(1);
            anew_nxt   = 1'b1;
            aid_nxt    = ID_W'(ap_cnt_r) + ID_W'(1);
            k_nxt      = '0;
            if (has_ssid)
              state_nxt = S_CRD;
            else
              op_done = 1'b1;
          end
        end else begin
          if (sta_cnt_r == CW'(STA_ENTRIES)) begin
            full_nxt = 1'b1;
          end else begin
            sta_we_mac  = 1'b1;
            sta_we_time = 1'b1;
            sta_we_chan = 1'b1;
            sta_we_link = 1'b1;
            sta_cnt_nxt = sta_cnt_r + CW'(1);
            snew_nxt    = 1'b1;
            sid_nxt     = ID_W'(sta_cnt_r) + ID_W'(1);
          end
          op_done = 1'b1;
        end
      end
      S_QRD: begin
        if (k_r == slen_r)
          op_done = 1'b1;
        else
          state_nxt = S_QCMP;
      end
      S_QCMP: begin
        if (fold(ss_q) != fold(fs_q)) begin
          k_nxt     = '0;
          state_nxt = S_CRD;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = S_QRD;
        end
      end
      S_CRD: begin
        if (k_r == slen_r) begin
          ap_we_len = 1'b1;
          ap_wlen   = slen_r;
          op_done   = 1'b1;
        end else begin
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        ss_we     = 1'b1;
        k_nxt     = k_r + KW'(1);
        state_nxt = S_CRD;
      end
      S_LK0: begin
        if (sid_r == '0 || aid_r == '0)
          state_nxt = S_OUT;
        else
          state_nxt = S_LK1;
      end
      S_LK1: begin
        if (sta_link_q == aid_r) begin
          state_nxt = S_OUT;
        end else begin
          sta_we_link = 1'b1;
          sta_wlink   = aid_r;
          moved_nxt   = 1'b1;
          old_nxt     = sta_link_q;
          state_nxt   = (sta_link_q != '0) ? S_LK2 : S_LK3;
        end
      end
      S_LK2: begin
        ap_we_tot = (ap_tot_q != '0);
        ap_wtot   = ap_tot_q - CW'(1);
        state_nxt = S_LK3;
      end
      S_LK3: begin
        state_nxt = S_LK4;
      end
      S_LK4: begin
        ap_we_tot = 1'b1;
        ap_wtot   = ap_tot_q + CW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'd0, full_r, moved_r, ch_r, snew_r, sid_r,
                            anew_r, aid_r, cls_r};
          clr            = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (op_done) begin
      idx_nxt = '0;
      if (!tbl_r) begin
        if (cls_r == CLS_PRSP) begin
          tbl_nxt   = 1'b1;
          key_nxt   = frm.addr2;
          state_nxt = S_SRD;
        end else if (cls_r == CLS_DATA) begin
          state_nxt = S_LK0;
        end else begin
          state_nxt = S_OUT;
        end
      end else begin
        if (cls_r == CLS_DATA) begin
          tbl_nxt   = 1'b0;
          key_nxt   = frm.addr1;
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sec_r        <= '0;
      ap_cnt_r     <= '0;
      sta_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sec_r        <= sec_nxt;
      ap_cnt_r     <= ap_cnt_nxt;
      sta_cnt_r    <= sta_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r       <= cls_nxt;
    slen_r      <= slen_nxt;
    k_r         <= k_nxt;
    ch_r        <= ch_nxt;
    tbl_r       <= tbl_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    aid_r       <= aid_nxt;
    sid_r       <= sid_nxt;
    old_r       <= old_nxt;
    anew_r      <= anew_nxt;
    snew_r      <= snew_nxt;
    moved_r     <= moved_nxt;
    full_r      <= full_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (fs_we)
      fs_mem[fs_waddr] <= in_tdata;
    fs_q <= fs_mem[k_r[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ss_we)
      ss_mem[{idx_r[AIW-1:0], k_r[SAW-1:0]}] <= fs_q;
    ss_q <= ss_mem[{idx_r[AIW-1:0], k_r[SAW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (ap_we_mac)
      ap_mac_mem[ap_waddr] <= key_r;
    if (ap_we_len)
      ap_len_mem[ap_waddr] <= ap_wlen;
    if (ap_we_tot)
      ap_tot_mem[ap_waddr] <= ap_wtot;
    if (ap_we_chan)
      ap_chan_mem[ap_waddr] <= ch_r;
    if (ap_we_time)
      ap_time_mem[ap_waddr] <= sec_r;
    ap_mac_q <= ap_mac_mem[ap_raddr];
    ap_len_q <= ap_len_mem[ap_raddr];
    ap_tot_q <= ap_tot_mem[ap_raddr];
  end

  always_ff @(posedge clk) begin
    if (sta_we_mac)
      sta_mac_mem[sta_waddr] <= key_r;
    if (sta_we_link)
      sta_link_mem[sta_waddr] <= sta_wlink;
    if (sta_we_chan)
      sta_chan_mem[sta_waddr] <= ch_r;
    if (sta_we_time)
      sta_time_mem[sta_waddr] <= sec_r;
    sta_mac_q  <= sta_mac_mem[sta_raddr];
    sta_link_q <= sta_link_mem[sta_raddr];
  end

endmodule

[design/wfdt_parse.sv]
`timescale 1ns / 1ps
module wfdt_parse import wfdt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic       clr,
  input  logic [7:0] data_byte,
  output frame_t     frm
);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    ftype_r, ftype_nxt;
  logic [47:0]   a1_r, a1_nxt, a2_r, a2_nxt;
  logic [7:0]    sslen_r, sslen_nxt;
  logic [PW-1:0] ntp_r, ntp_nxt;
  logic [7:0]    chan_r, chan_nxt;
  logic          seen_r, seen_nxt, walk_r, walk_nxt, hit_r, hit_nxt;

  always_comb begin
    pos_nxt   = pos_r;
    ftype_nxt = ftype_r;
    a1_nxt    = a1_r;
    a2_nxt    = a2_r;
    sslen_nxt = sslen_r;
    ntp_nxt   = ntp_r;
    chan_nxt  = chan_r;
    seen_nxt  = seen_r;
    walk_nxt  = walk_r;
    hit_nxt   = hit_r;
    if (clr) begin
      pos_nxt   = '0;
      ftype_nxt = '0;
      a1_nxt    = '0;
      a2_nxt    = '0;
      sslen_nxt = '0;
      ntp_nxt   = '0;
      chan_nxt  = '0;
      seen_nxt  = 1'b0;
      walk_nxt  = 1'b0;
      hit_nxt   = 1'b0;
    end else if (take && pos_r < PW'(MAX_FRAME_BYTES)) begin
      pos_nxt = pos_r + PW'(1);
      if (pos_r == '0) begin
        ftype_nxt = data_byte;
        walk_nxt  = (data_byte == FT_PREQ) || (data_byte == FT_PRSP) ||
                    (data_byte == FT_BCN);
        ntp_nxt   = (data_byte == FT_PREQ) ? PW'(WALK_PREQ) : PW'(WALK_MGMT);
        hit_nxt   = 1'b0;
      end
      if (pos_r >= PW'(ADDR1_POS) && pos_r < PW'(ADDR1_POS + 6))
        a1_nxt = {a1_r[39:0], data_byte};
      if (pos_r >= PW'(ADDR2_POS) && pos_r < PW'(ADDR2_POS + 6))
        a2_nxt = {a2_r[39:0], data_byte};
      if (pos_r == PW'(SSID_LEN_POS))
        sslen_nxt = data_byte;
      if (walk_r && pos_r != '0) begin
        if (pos_r == ntp_r) begin
          hit_nxt = (data_byte == TAG_DS);
        end else if (pos_r == ntp_r + PW'(1)) begin
          if (!hit_r)
            ntp_nxt = ntp_r + PW'(2) + PW'(data_byte);
        end else if (hit_r && pos_r == ntp_r + PW'(2)) begin
          chan_nxt = data_byte;
          seen_nxt = 1'b1;
          walk_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ftype_r <= '0;
      a1_r    <= '0;
      a2_r    <= '0;
      sslen_r <= '0;
      ntp_r   <= '0;
      chan_r  <= '0;
      seen_r  <= 1'b0;
      walk_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      ftype_r <= ftype_nxt;
      a1_r    <= a1_nxt;
      a2_r    <= a2_nxt;
      sslen_r <= sslen_nxt;
      ntp_r   <= ntp_nxt;
      chan_r  <= chan_nxt;
      seen_r  <= seen_nxt;
      walk_r  <= walk_nxt;
      hit_r   <= hit_nxt;
    end
  end

  assign frm = '{pos: pos_r, ftype: ftype_r, addr1: a1_r, addr2: a2_r,
                 sslen: sslen_r, chan: chan_r, seen: seen_r};

endmodule

[design/wfdt_chk.sv]
`timescale 1ns / 1ps
module wfdt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4)
    else $error("bad frame class");

  a_ignored_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == 3'd0 |->
      out_tdata[8:3] == 6'd0 && out_tdata[15:10] == 6'd0 &&
      out_tdata[24:17] == 8'd0 && !out_tdata[25] && !out_tdata[26])
    else $error("ignored frame touched a table");

  a_assoc_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[25] |->
      out_tdata[2:0] == 3'd4 && out_tdata[8:3] != 6'd0 && out_tdata[15:10] != 6'd0)
    else $error("link change outside a data frame");

  a_data_nochan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == 3'd4 |-> out_tdata[24:17] == 8'd0)
    else $error("data frame carried a channel");

endmodule

bind wifi_frame_device_tracker wfdt_chk u_chk (.*);

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
  import wfdt_pkg::*;

  class tracker_model;
    int unsigned pos;
    bit [7:0]  ftype;
    bit [47:0] addr1, addr2;
    bit [7:0]  ssid_size;
    bit [7:0]  ssid_buf [SSID_BYTES];
    int unsigned tag_pos;
    bit [7:0]  chan;
    bit        chan_seen, walking, tag_hit;
    bit [31:0] secs;

    int unsigned ap_n;
    bit [47:0] ap_mac [AP_ENTRIES];
    bit [7:0]  ap_ssid [AP_ENTRIES][SSID_BYTES];
    int unsigned ap_slen [AP_ENTRIES];
    bit [7:0]  ap_chan [AP_ENTRIES];
    bit [31:0] ap_time [AP_ENTRIES];
    int unsigned ap_stas [AP_ENTRIES];

    int unsigned sta_n;
    bit [47:0] sta_mac [STA_ENTRIES];
    bit [7:0]  sta_chan [STA_ENTRIES];
    bit [31:0] sta_time [STA_ENTRIES];
    int unsigned sta_link [STA_ENTRIES];

    bit [31:0] reports [$];
    int fails;

    function new();
      secs = 0;
      ap_n = 0;
      sta_n = 0;
      fails = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = 0;
      ftype = 0;
      addr1 = 0;
      addr2 = 0;
      ssid_size = 0;
      tag_pos = 0;
      chan = 0;
      chan_seen = 0;
      walking = 0;
      tag_hit = 0;
    endfunction

    function bit [7:0] to_lower(bit [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function int unsigned find_ap(bit [47:0] mac, bit with_ssid, int unsigned slen,
                                  bit [7:0] ch, inout bit created, inout bit full);
      int unsigned i;
      bit same;
      for (i = 0; i < ap_n; i++)
        if (ap_mac[i] == mac) break;
      if (i < ap_n) begin
        if (with_ssid) begin
          same = (ap_slen[i] == slen);
          for (int k = 0; same && k < slen; k++)
            if (to_lower(ap_ssid[i][k]) != to_lower(ssid_buf[k])) same = 0;
          if (!same) begin
            for (int k = 0; k < slen; k++) ap_ssid[i][k] = ssid_buf[k];
            ap_slen[i] = slen;
          end
        end
        ap_time[i] = secs;
        if (ch != 0) ap_chan[i] = ch;
        return i + 1;
      end
      if (ap_n >= AP_ENTRIES) begin
        full = 1;
        return 0;
      end
      ap_mac[i] = mac;
      ap_time[i] = secs;
      ap_chan[i] = ch;
      ap_stas[i] = 0;
      ap_slen[i] = 0;
      if (with_ssid) begin
        for (int k = 0; k < slen; k++) ap_ssid[i][k] = ssid_buf[k];
        ap_slen[i] = slen;
      end
      ap_n++;
      created = 1;
      return i + 1;
    endfunction

    function int unsigned find_sta(bit [47:0] mac, bit [7:0] ch,
                                   inout bit created, inout bit full);
      int unsigned i;
      for (i = 0; i < sta_n; i++)
        if (sta_mac[i] == mac) break;
      if (i < sta_n) begin
        sta_time[i] = secs;
        if (ch != 0) sta_chan[i] = ch;
        return i + 1;
      end
      if (sta_n >= STA_ENTRIES) begin
        full = 1;
        return 0;
      end
      sta_mac[i] = mac;
      sta_time[i] = secs;
      sta_chan[i] = ch;
      sta_link[i] = 0;
      sta_n++;
      created = 1;
      return i + 1;
    endfunction

    function bit relink(int unsigned sid, int unsigned aid);
      int unsigned prev;
      if (sid == 0 || aid == 0) return 0;
      prev = sta_link[sid-1];
      if (prev == aid) return 0;
      if (prev != 0 && ap_stas[prev-1] > 0) ap_stas[prev-1]--;
      ap_stas[aid-1]++;
      sta_link[sid-1] = aid;
      return 1;
    endfunction

    function void take_byte(int unsigned p, bit [7:0] b);
      if (p == 0) begin
        ftype = b;
        walking = (b == FT_PREQ || b == FT_PRSP || b == FT_BCN);
        tag_pos = (b == FT_PREQ) ? WALK_PREQ : WALK_MGMT;
        tag_hit = 0;
      end
      if (p >= ADDR1_POS && p < ADDR1_POS + 6) addr1 = {addr1[39:0], b};
      if (p >= ADDR2_POS && p < ADDR2_POS + 6) addr2 = {addr2[39:0], b};
      if (p == SSID_LEN_POS) ssid_size = b;
      if (p >= SSID_POS && p < SSID_POS + SSID_BYTES) ssid_buf[p - SSID_POS] = b;
      if (walking && p != 0) begin
        if (p == tag_pos) tag_hit = (b == TAG_DS);
        else if (p == tag_pos + 1) begin
          if (!tag_hit) tag_pos += 2 + b;
        end else if (tag_hit && p == tag_pos + 2) begin
          chan = b;
          chan_seen = 1;
          walking = 0;
        end
      end
    endfunction

    function void take_transfer(bit tick, bit [7:0] b, bit fin);
      bit [2:0] cls;
      int unsigned aid, sid, slen;
      bit anew, snew, full, moved;
      bit [7:0] ch;
      if (tick) begin
        secs++;
        return;
      end
      if (pos < MAX_FRAME_BYTES) begin
        take_byte(pos, b);
        pos++;
      end
      if (!fin) return;
      aid = 0; sid = 0; slen = 0;
      anew = 0; snew = 0; full = 0; moved = 0;
      ch = chan_seen ? chan : 8'd0;
      case (ftype)
        FT_PREQ: cls = CLS_PREQ;
        FT_PRSP: cls = CLS_PRSP;
        FT_BCN: cls = CLS_BCN;
        FT_QDATA, FT_DATA: cls = CLS_DATA;
        default: cls = CLS_NONE;
      endcase
      if (pos < MIN_FRAME) cls = CLS_NONE;
      if (cls == CLS_PRSP || cls == CLS_BCN) begin
        slen = (ssid_size > SSID_BYTES) ? SSID_BYTES : ssid_size;
        if (pos < SSID_POS) slen = 0;
        else if (slen > pos - SSID_POS) slen = pos - SSID_POS;
      end
      case (cls)
        CLS_PREQ: sid = find_sta(addr2, ch, snew, full);
        CLS_PRSP: begin
          sid = find_sta(addr1, ch, snew, full);
          aid = find_ap(addr2, 1, slen, ch, anew, full);
        end
        CLS_BCN: aid = find_ap(addr2, 1, slen, ch, anew, full);
        CLS_DATA: begin
          ch = 0;
          aid = find_ap(addr2, 0, 0, 0, anew, full);
          sid = find_sta(addr1, 0, snew, full);
          moved = relink(sid, aid);
        end
        default: ch = 0;
      endcase
      reports.push_back({5'd0, full, moved, ch, snew, sid[5:0], anew, aid[5:0], cls});
      clear_frame();
    endfunction

    function void check_frame_report(bit [31:0] got);
      bit [31:0] want;
      string names [8] = '{"frame_class", "ap_id", "ap_new", "sta_id", "sta_new",
                           "channel_found", "assoc_changed", "status"};
      int lo [8] = '{0, 3, 9, 10, 16, 17, 25, 26};
      int wd [8] = '{3, 6, 1, 6, 1, 8, 1, 1};
      if (reports.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %h", got);
        return;
      end
      want = reports.pop_front();
      for (int f = 0; f < 8; f++)
        if (((want >> lo[f]) & ((1 << wd[f]) - 1)) != ((got >> lo[f]) & ((1 << wd[f]) - 1)))
        begin
          fails++;
          if (fails <= 10)
            $display("%s mismatch: expected %0d actual %0d", names[f],
                     (want >> lo[f]) & ((1 << wd[f]) - 1),
                     (got >> lo[f]) & ((1 << wd[f]) - 1));
        end
      if (got[31:27] != 0) begin
        fails++;
        if (fails <= 10) $display("padding bits set: %h", got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic in_tuser = 0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;

  tracker_model sb = new();
  bit no_idle_in, no_idle_out, hold_out;
  int items, idle_cycles;
  bit [47:0] macs [48];
  bit [7:0] frame [$];

  always #5 clk = ~clk;

  wifi_frame_device_tracker u_top (.*);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(bit tick, bit [7:0] b, bit fin);
    int gap;
    gap = no_idle_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= tick;
    in_tdata <= b;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    sb.take_transfer(tick, b, fin);
    items++;
  endtask

  task automatic send_frame(bit ticks);
    for (int i = 0; i < frame.size(); i++) begin
      if (ticks && $urandom_range(0, 15) == 0) send(1, $urandom, $urandom);
      send(0, frame[i], i == frame.size() - 1);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.reports.size() != 0) @(posedge clk);
  endtask

  function automatic void put_mac(bit [47:0] m);
    for (int k = 5; k >= 0; k--) frame.push_back(m[8*k +: 8]);
  endfunction

  // ssid_kind: 0 random text, 1 upper case, 2 lower case of the same name
  function automatic void build_mgmt(bit [7:0] ft, bit [47:0] a1, bit [47:0] a2,
                                     int slen, int ssid_kind, bit with_ch, bit [7:0] ch,
                                     int filler, bit short_ds);
    frame.delete();
    frame.push_back(ft);
    repeat (3) frame.push_back($urandom);
    put_mac(a1);
    put_mac(a2);
    while (frame.size() < ((ft == FT_PREQ) ? WALK_PREQ : WALK_MGMT)) frame.push_back($urandom);
    frame.push_back(8'h00);
    frame.push_back(slen);
    for (int k = 0; k < slen; k++)
      case (ssid_kind)
        1: frame.push_back("A" + (k % 26));
        2: frame.push_back("a" + (k % 26));
        default: frame.push_back($urandom_range(32, 126));
      endcase
    if (filler >= 0) begin
      frame.push_back($urandom_range(4, 255));
      frame.push_back(filler);
      repeat (filler) frame.push_back($urandom);
    end
    if (with_ch) begin
      frame.push_back(TAG_DS);
      frame.push_back(short_ds ? 8'd0 : 8'd1);
      frame.push_back(ch);
    end
    repeat ($urandom_range(0, 3)) frame.push_back($urandom);
  endfunction

  function automatic void build_data(bit [7:0] ft, bit [47:0] a1, bit [47:0] a2, int extra);
    frame.delete();
    frame.push_back(ft);
    repeat (3) frame.push_back($urandom);
    put_mac(a1);
    put_mac(a2);
    repeat (extra) frame.push_back($urandom);
  endfunction

  function automatic void build_noise(int len);
    frame.delete();
    repeat (len) frame.push_back($urandom);
  endfunction

  function automatic bit [47:0] any_mac();
    return macs[$urandom_range(0, 47)];
  endfunction

  initial begin
    forever begin
      int gap;
      if (hold_out) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_out = 0;
      end
      gap = no_idle_out ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_frame_report(out_tdata);
    end
  end

  initial begin
    bit [7:0] ftypes [5] = '{FT_PREQ, FT_PRSP, FT_BCN, FT_QDATA, FT_DATA};
    int sel;
    macs[0] = '0;
    macs[1] = '1;
    for (int i = 2; i < 48; i++) macs[i] = {$urandom, $urandom};
    repeat (3) @(posedge clk);
    rst_n <= 1;

    send(1, 8'hFF, 1);
    build_noise(10);
    frame[0] = FT_BCN;
    send_frame(0);
    build_data(8'h33, macs[2], macs[3], 10);
    send_frame(0);
    build_mgmt(FT_PREQ, macs[0], macs[1], 4, 0, 1, 8'd255, 3, 0);
    send_frame(1);
    build_mgmt(FT_PRSP, macs[4], macs[5], 8, 1, 1, 8'd6, -1, 0);
    send_frame(1);
    build_mgmt(FT_BCN, macs[6], macs[5], 8, 2, 1, 8'd11, -1, 0);
    send_frame(1);
    build_mgmt(FT_BCN, macs[6], macs[5], 6, 0, 0, 8'd0, 2, 0);
    send_frame(1);
    build_mgmt(FT_BCN, macs[6], macs[7], 40, 0, 1, 8'd1, -1, 1);
    send_frame(1);
    build_mgmt(FT_PRSP, macs[4], macs[7], 20, 0, 0, 8'd0, -1, 0);
    frame[SSID_LEN_POS] = 8'd200;
    frame = frame[0:SSID_POS + 5];
    send_frame(0);
    build_data(FT_DATA, macs[4], macs[5], 4);
    send_frame(0);
    build_data(FT_QDATA, macs[4], macs[7], 0);
    send_frame(0);
    build_data(FT_QDATA, macs[4], macs[7], 2);
    send_frame(0);
    build_noise(1);
    send_frame(0);
    drain();

    for (int phase = 0; items < 900 || phase < 4; phase++) begin
      no_idle_in = (phase % 4 == 1);
      no_idle_out = (phase % 4 == 2);
      if (phase == 3) hold_out = 1;
      repeat (3) begin
        sel = $urandom_range(0, 19);
        if (sel < 3) build_noise($urandom_range(1, 40));
        else if (sel < 8) build_data(ftypes[$urandom_range(3, 4)], any_mac(), any_mac(),
                                     $urandom_range(0, 8));
        else begin
          build_mgmt(ftypes[$urandom_range(0, 2)], any_mac(), any_mac(),
                     $urandom_range(0, 36), $urandom_range(0, 2), $urandom_range(0, 3) != 0,
                     $urandom, $urandom_range(0, 1) ? -1 : $urandom_range(0, 5),
                     $urandom_range(0, 7) == 0);
          if (sel == 19) frame = frame[0:$urandom_range(0, frame.size() - 1)];
        end
        send_frame(1);
      end
      if (phase % 2 == 0) drain();
      if (phase >= 40) break;
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.fails == 0 && sb.reports.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[wifi_frame_device_tracker.f]
design/wfdt_pkg.sv
design/wfdt_parse.sv
design/wifi_frame_device_tracker.sv
design/wfdt_chk.sv
test/tb.sv
